>>> sv/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEF  = 32;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int TOTAL_W        = 32;

    localparam logic [TOTAL_W-1:0] MAX_BODY_RESET = 32'd1048576;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_DATA    = 4'd2,
        PH_DATA_CR = 4'd3,
        PH_DATA_LF = 4'd4,
        PH_END_CR  = 4'd5,
        PH_END_LF  = 4'd6,
        PH_DONE    = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_BAD   = 2'd2,
        ST_LARGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_CR    = 2'd1,
        K_LF    = 2'd2,
        K_OTHER = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [1:0] body_status;
    } t_out_item;

    // classified byte, handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [3:0] hex;
        logic [7:0] data;
        logic       start;
    } t_class;

    typedef struct packed {
        logic               we;
        logic [TOTAL_W-1:0] wdata;
    } t_cfg_wr;

endpackage

`default_nettype wire

>>> sv/hcbd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/hcbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_front #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hcbd_pkg::t_in_item i_item,
    output logic                   o_full,
    input  wire logic              i_take,
    output hcbd_pkg::t_class       o_cls,
    output logic                   o_empty
);

    import hcbd_pkg::*;

    localparam int CLS_W = $bits(t_class);

    function automatic t_class classify(input t_in_item item);
        t_class c;
        c.data  = item.in_byte;
        c.start = item.body_start;
        c.hex   = '0;
        c.kind  = K_OTHER;
        unique case (item.in_byte) inside
            [8'h30:8'h39]: begin
                c.kind = K_DIGIT;
                c.hex  = 4'(item.in_byte - 8'h30);
            end
            [8'h61:8'h66]: begin
                c.kind = K_DIGIT;
                c.hex  = 4'(item.in_byte - 8'h57);
            end
            [8'h41:8'h46]: begin
                c.kind = K_DIGIT;
                c.hex  = 4'(item.in_byte - 8'h37);
            end
            CH_CR: c.kind = K_CR;
            CH_LF: c.kind = K_LF;
            default: c.kind = K_OTHER;
        endcase
        return c;
    endfunction

    t_class           cls_in;
    logic [CLS_W-1:0] cls_out;

    assign cls_in = classify(i_item);
    assign o_cls  = cls_out;

    hcbd_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_in),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (cls_out),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

>>> sv/hcbd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_back #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hcbd_pkg::t_cfg_wr  i_cfg,
    input  wire hcbd_pkg::t_class   i_cls,
    input  wire logic               i_cls_valid,
    output logic                    o_cls_take,
    output hcbd_pkg::t_out_item     o_res,
    output logic                    o_res_push,
    input  wire logic               i_res_full
);

    import hcbd_pkg::*;

    t_phase               r_phase, n_phase;
    t_status              r_status, n_status;
    logic [SIZE_BITS-1:0] r_rem, n_rem;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic                 r_digits, n_digits;
    logic [TOTAL_W-1:0]   r_max;

    assign o_cls_take = i_cls_valid && !i_res_full;
    assign o_res_push = o_cls_take;

    always_comb begin
        t_phase               ph;
        logic [SIZE_BITS-1:0] rem;
        logic [TOTAL_W-1:0]   total;
        logic                 digits;
        t_status              st;
        ph     = r_phase;
        rem    = r_rem;
        total  = r_total;
        digits = r_digits;
        st     = r_status;
        if (i_cls.start) begin
            ph     = PH_SIZE;
            rem    = '0;
            total  = '0;
            digits = 1'b0;
            st     = ST_BUSY;
        end
        n_phase  = ph;
        n_rem    = rem;
        n_total  = total;
        n_digits = digits;
        n_status = st;
        o_res.out_byte  = '0;
        o_res.out_valid = 1'b0;
        unique case (ph) inside
            PH_SIZE: begin
                if (i_cls.kind == K_DIGIT) begin
                    if (rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_phase  = PH_DONE;
                        n_status = ST_BAD;
                    end else begin
                        n_rem    = {rem[SIZE_BITS-5:0], i_cls.hex};
                        n_digits = 1'b1;
                    end
                end else if (i_cls.kind == K_CR && digits) begin
                    n_phase = PH_SIZE_LF;
                end else begin
                    n_phase  = PH_DONE;
                    n_status = ST_BAD;
                end
            end
            PH_SIZE_LF: begin
                n_digits = 1'b0;
                if (i_cls.kind != K_LF) begin
                    n_phase  = PH_DONE;
                    n_status = ST_BAD;
                end else begin
                    n_phase = (rem == '0) ? PH_END_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                // total before this byte at the limit means this byte is the excess one
                if (total >= r_max) begin
                    n_phase  = PH_DONE;
                    n_status = ST_LARGE;
                end else begin
                    o_res.out_byte  = i_cls.data;
                    o_res.out_valid = 1'b1;
                    n_total = total + 1'b1;
                    n_rem   = rem - 1'b1;
                    if (rem == SIZE_BITS'(1)) begin
                        n_phase = PH_DATA_CR;
                    end
                end
            end
            PH_DATA_CR, PH_END_CR: begin
                if (i_cls.kind == K_CR) begin
                    n_phase = (ph == PH_DATA_CR) ? PH_DATA_LF : PH_END_LF;
                end else begin
                    n_phase  = PH_DONE;
                    n_status = ST_BAD;
                end
            end
            PH_DATA_LF: begin
                if (i_cls.kind == K_LF) begin
                    n_phase  = PH_SIZE;
                    n_digits = 1'b0;
                    n_rem    = '0;
                end else begin
                    n_phase  = PH_DONE;
                    n_status = ST_BAD;
                end
            end
            PH_END_LF: begin
                n_phase  = PH_DONE;
                n_status = (i_cls.kind == K_LF) ? ST_DONE : ST_BAD;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        o_res.body_status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIZE;
            r_status <= ST_BUSY;
            r_rem    <= '0;
            r_total  <= '0;
            r_digits <= 1'b0;
        end else if (o_cls_take) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_rem    <= n_rem;
            r_total  <= n_total;
            r_digits <= n_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_BODY_RESET;
        end else if (i_cfg.we) begin
            r_max <= i_cfg.wdata;
        end
    end

endmodule

`default_nettype wire

>>> sv/http_chunked_body_decoder_unit.sv
// chunked body decoder: one raw byte in, one result out per byte
// throughput: one byte per cycle while the result queue has room, set by the parser update in the back end
// path: an accepted byte crosses two queues, front then result, before its result can be popped
// reset: synchronous active-low i_rst_n empties both queues, returns the parser to an
// empty size line and loads the body limit with its default of 1048576
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
    parameter int FIFO_DEPTH = hcbd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration: body size limit
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata,
    // raw byte requests
    input  wire logic                push,
    input  wire hcbd_pkg::t_in_item  i_in_item,
    output logic                     full,
    // decoded result requests
    output logic                     empty,
    input  wire logic                pop,
    output hcbd_pkg::t_out_item      o_out_item
);

    import hcbd_pkg::*;

    localparam int RES_W = $bits(t_out_item);

    t_cfg_wr          cfg_wr;
    t_class           cls;
    logic             cls_empty;
    logic             cls_take;
    t_out_item        res;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_head;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.wdata = i_cfg_wdata;

    // front end: decode the byte as hex digit, cr, lf or other and queue it
    hcbd_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .i_take  (cls_take),
        .o_cls   (cls),
        .o_empty (cls_empty)
    );

    // back end: chunk parser, advances one classified byte per cycle while
    // the result queue has room
    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cls       (cls),
        .i_cls_valid (!cls_empty),
        .o_cls_take  (cls_take),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // result queue: decouples parser from the consumer's pop
    hcbd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (FIFO_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_out_item = res_head;

`ifndef SYNTH
    // data only passes while the body is still open
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.out_valid) |-> (o_out_item.body_status == ST_BUSY))
        else $error("data byte delivered with a closed body status");

    // non-data results carry a zero byte
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.out_valid) |-> (o_out_item.out_byte == 8'd0))
        else $error("non-data result with nonzero byte");

    // no result may appear right out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire
